/* rtl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and defaults for the stack machine execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

	localparam int unsigned STACK_DEPTH_DEF  = 64;
	localparam int unsigned RETURN_DEPTH_DEF = 16;
	localparam int unsigned REG_COUNT_DEF    = 4;
	localparam int unsigned MEM_WORDS_DEF    = 1024;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_OUT   = 4'd1,
		OP_ADD   = 4'd2,
		OP_SUB   = 4'd3,
		OP_MUL   = 4'd4,
		OP_DIV   = 4'd5,
		OP_SQRT  = 4'd6,
		OP_PUSHR = 4'd7,
		OP_POPR  = 4'd8,
		OP_JMP   = 4'd9,
		OP_JCOND = 4'd10,
		OP_CALL  = 4'd11,
		OP_RET   = 4'd12,
		OP_PUSHM = 4'd13,
		OP_POPM  = 4'd14
	} op_t;

	typedef enum logic [3:0] {
		ERR_OK      = 4'd0,
		ERR_UNDER   = 4'd1,
		ERR_OVER    = 4'd2,
		ERR_DIVZ    = 4'd3,
		ERR_SQRTNEG = 4'd4,
		ERR_BADREG  = 4'd5,
		ERR_SEG     = 4'd6,
		ERR_RUNDER  = 4'd7,
		ERR_ROVER   = 4'd8
	} err_t;

	typedef enum logic [2:0] {
		CND_GT = 3'd0,
		CND_GE = 3'd1,
		CND_LT = 3'd2,
		CND_LE = 3'd3,
		CND_EQ = 3'd4,
		CND_NE = 3'd5
	} cond_t;

	typedef enum logic [1:0] {
		AU_MUL  = 2'd0,
		AU_DIV  = 2'd1,
		AU_SQRT = 2'd2
	} au_op_t;

	// controller -> datapath
	typedef struct packed {
		logic clr;
		logic ld;
		logic rd_a;
		logic rd_b;
		logic rd_m;
		logic start;
		logic commit;
	} smx_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic need_unit;
		logic unit_done;
		logic fault;
	} smx_sts_t;

endpackage

/* rtl/smx_if.sv */
// ----------------------------------------------------------------------------
// smx_req_if / smx_rsp_if
// Valid/ready channels for instruction words and result words.
// ----------------------------------------------------------------------------
interface smx_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         cmd;
	logic signed [63:0] argument;
	logic [2:0]         condition;

	modport source (output valid, cmd, argument, condition, input ready);
	modport sink   (input valid, cmd, argument, condition, output ready);
endinterface

interface smx_rsp_if;
	logic               valid;
	logic               ready;
	logic [15:0]        next_ip;
	logic               print_valid;
	logic signed [63:0] print_value;
	logic [3:0]         error_code;

	modport source (output valid, next_ip, print_valid, print_value, error_code, input ready);
	modport sink   (input valid, next_ip, print_valid, print_value, error_code, output ready);
endinterface

/* rtl/smx_arith.sv */
// ----------------------------------------------------------------------------
// smx_arith
// Iterative multiply, signed divide and integer square root, one bit
// (two for sqrt) per cycle, with a final sign-fix step.
// ----------------------------------------------------------------------------
module smx_arith (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  smx_pkg::au_op_t      op,
	input  logic [63:0]          x,
	input  logic [63:0]          y,
	output logic                 done,
	output logic [63:0]          result
);

	smx_pkg::au_op_t op_q;
	logic [63:0] acc_q, x_q, y_q;
	logic [64:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q, neg_q;

	logic [64:0] div_sh, sq_sh, sq_trial;

	assign div_sh   = {rem_q[63:0], x_q[63]};
	assign sq_sh    = {rem_q[62:0], x_q[63:62]};
	assign sq_trial = {acc_q[62:0], 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (op == smx_pkg::AU_SQRT) ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				if (cnt_q != 7'd0) begin
					cnt_q <= cnt_q - 7'd1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			acc_q <= '0;
			rem_q <= '0;
			case (op)
				smx_pkg::AU_DIV: begin
					x_q   <= x[63] ? (64'd0 - x) : x;
					y_q   <= y[63] ? (64'd0 - y) : y;
					neg_q <= x[63] ^ y[63];
				end
				smx_pkg::AU_SQRT: begin
					x_q   <= y;
					y_q   <= '0;
					neg_q <= 1'b0;
				end
				default: begin
					x_q   <= x;
					y_q   <= y;
					neg_q <= 1'b0;
				end
			endcase
		end else if (busy_q) begin
			if (cnt_q == 7'd0) begin
				acc_q <= neg_q ? (64'd0 - acc_q) : acc_q;
			end else begin
				case (op_q)
					smx_pkg::AU_MUL: begin
						if (y_q[0])
							acc_q <= acc_q + x_q;
						x_q <= {x_q[62:0], 1'b0};
						y_q <= {1'b0, y_q[63:1]};
					end
					smx_pkg::AU_DIV: begin
						x_q <= {x_q[62:0], 1'b0};
						if (div_sh >= {1'b0, y_q}) begin
							rem_q <= div_sh - {1'b0, y_q};
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= div_sh;
							acc_q <= {acc_q[62:0], 1'b0};
						end
					end
					smx_pkg::AU_SQRT: begin
						x_q <= {x_q[61:0], 2'b00};
						if (sq_sh >= sq_trial) begin
							rem_q <= sq_sh - sq_trial;
							acc_q <= {acc_q[62:0], 1'b1};
						end else begin
							rem_q <= sq_sh;
							acc_q <= {acc_q[62:0], 1'b0};
						end
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

/* rtl/smx_dpath.sv */
// ----------------------------------------------------------------------------
// smx_dpath
// Stacks, registers, data RAM, instruction pointer and result register.
// ----------------------------------------------------------------------------
module smx_dpath #(
	parameter int unsigned STACK_DEPTH  = smx_pkg::STACK_DEPTH_DEF,
	parameter int unsigned RETURN_DEPTH = smx_pkg::RETURN_DEPTH_DEF,
	parameter int unsigned REG_COUNT    = smx_pkg::REG_COUNT_DEF,
	parameter int unsigned MEM_WORDS    = smx_pkg::MEM_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smx_pkg::smx_ctl_t  ctl,
	output smx_pkg::smx_sts_t  sts,
	input  logic [3:0]         cmd,
	input  logic signed [63:0] argument,
	input  logic [2:0]         condition,
	output logic [15:0]        next_ip,
	output logic               print_valid,
	output logic signed [63:0] print_value,
	output logic [3:0]         error_code
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SDW = $clog2(STACK_DEPTH + 1);
	localparam int RAW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
	localparam int RDW = $clog2(RETURN_DEPTH + 1);
	localparam int RGW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	// instruction word
	logic [3:0]  op_q;
	logic [63:0] arg_q;
	logic [2:0]  cnd_q;

	// architectural state
	logic [15:0]    ip_q;
	logic [SDW-1:0] d_q;
	logic [RDW-1:0] rdp_q;
	logic           fault_q;

	logic [63:0] sp_mem [STACK_DEPTH];
	logic [63:0] sp_rd_q, a_q, b_q;
	logic [15:0] rs_mem [RETURN_DEPTH];
	logic [63:0] rg_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rg_vld_q;
	logic [63:0] rg_rd_q;
	logic        rg_rv_q;
	logic [63:0] dm_mem [MEM_WORDS];
	logic [63:0] dm_rd_q;
	logic [MAW-1:0] clr_cnt_q;

	// result word
	logic [15:0] nip_q;
	logic        pv_q;
	logic [63:0] pval_q;
	logic [3:0]  err_q;

	logic [SDW-1:0] d_m1, d_m2;
	logic [RDW-1:0] rdp_m1;
	logic [63:0]    regv;
	logic           reg_ok, addr_ok, under1, under2, over, taken;
	logic [3:0]     err;
	logic           ok_commit;
	logic [15:0]    ip_nx;
	logic [SDW-1:0] d_nx;

	logic           sp_we;
	logic [SAW-1:0] sp_wa, sp_ra;
	logic [63:0]    sp_wd;
	logic           dm_we;
	logic [MAW-1:0] dm_addr;
	logic [63:0]    dm_wd;

	smx_pkg::au_op_t au_op;
	logic            au_done;
	logic [63:0]     au_res;

	assign d_m1   = d_q - SDW'(1);
	assign d_m2   = d_q - SDW'(2);
	assign rdp_m1 = rdp_q - RDW'(1);
	assign regv   = rg_rv_q ? rg_rd_q : 64'd0;
	assign reg_ok  = !arg_q[63] && (arg_q < 64'(REG_COUNT));
	assign addr_ok = !regv[63] && (regv < 64'(MEM_WORDS));
	assign under1 = (d_q < SDW'(1));
	assign under2 = (d_q < SDW'(2));
	assign over   = (d_q >= SDW'(STACK_DEPTH));

	always_comb begin
		case (cnd_q)
			smx_pkg::CND_GT: taken = $signed(a_q) >  $signed(b_q);
			smx_pkg::CND_GE: taken = $signed(a_q) >= $signed(b_q);
			smx_pkg::CND_LT: taken = $signed(a_q) <  $signed(b_q);
			smx_pkg::CND_LE: taken = $signed(a_q) <= $signed(b_q);
			smx_pkg::CND_EQ: taken = (a_q == b_q);
			smx_pkg::CND_NE: taken = (a_q != b_q);
			default:         taken = 1'b0;
		endcase
	end

	// error check, highest priority first
	always_comb begin
		err = smx_pkg::ERR_OK;
		case (op_q)
			smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL: begin
				if (under2) err = smx_pkg::ERR_UNDER;
			end
			smx_pkg::OP_DIV: begin
				if (under2) err = smx_pkg::ERR_UNDER;
				else if (a_q == 64'd0) err = smx_pkg::ERR_DIVZ;
			end
			smx_pkg::OP_PUSH: begin
				if (over) err = smx_pkg::ERR_OVER;
			end
			smx_pkg::OP_OUT: begin
				if (under1) err = smx_pkg::ERR_UNDER;
			end
			smx_pkg::OP_SQRT: begin
				if (under1) err = smx_pkg::ERR_UNDER;
				else if (a_q[63]) err = smx_pkg::ERR_SQRTNEG;
			end
			smx_pkg::OP_PUSHR: begin
				if (!reg_ok) err = smx_pkg::ERR_BADREG;
				else if (over) err = smx_pkg::ERR_OVER;
			end
			smx_pkg::OP_POPR: begin
				if (!reg_ok) err = smx_pkg::ERR_BADREG;
				else if (under1) err = smx_pkg::ERR_UNDER;
			end
			smx_pkg::OP_JCOND: begin
				if (under2) err = smx_pkg::ERR_UNDER;
			end
			smx_pkg::OP_CALL: begin
				if (rdp_q >= RDW'(RETURN_DEPTH)) err = smx_pkg::ERR_ROVER;
			end
			smx_pkg::OP_RET: begin
				if (rdp_q < RDW'(1)) err = smx_pkg::ERR_RUNDER;
			end
			smx_pkg::OP_PUSHM: begin
				if (!reg_ok) err = smx_pkg::ERR_BADREG;
				else if (!addr_ok) err = smx_pkg::ERR_SEG;
				else if (over) err = smx_pkg::ERR_OVER;
			end
			smx_pkg::OP_POPM: begin
				if (!reg_ok) err = smx_pkg::ERR_BADREG;
				else if (!addr_ok) err = smx_pkg::ERR_SEG;
				else if (under1) err = smx_pkg::ERR_UNDER;
			end
			default: err = smx_pkg::ERR_OK;
		endcase
	end

	always_comb begin
		case (op_q)
			smx_pkg::OP_DIV:  au_op = smx_pkg::AU_DIV;
			smx_pkg::OP_SQRT: au_op = smx_pkg::AU_SQRT;
			default:          au_op = smx_pkg::AU_MUL;
		endcase
	end

	assign ok_commit = ctl.commit && (err == smx_pkg::ERR_OK);

	// next ip, depth and stack write
	always_comb begin
		ip_nx = ip_q + 16'd1;
		d_nx  = d_q;
		sp_we = 1'b0;
		sp_wa = d_q[SAW-1:0];
		sp_wd = arg_q;
		case (op_q)
			smx_pkg::OP_PUSH: begin
				ip_nx = ip_q + 16'd2;
				d_nx  = d_q + SDW'(1);
				sp_we = 1'b1;
			end
			smx_pkg::OP_OUT: begin
				d_nx = d_m1;
			end
			smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
				d_nx  = d_m1;
				sp_we = 1'b1;
				sp_wa = d_m2[SAW-1:0];
				if (op_q == smx_pkg::OP_ADD)      sp_wd = b_q + a_q;
				else if (op_q == smx_pkg::OP_SUB) sp_wd = b_q - a_q;
				else                              sp_wd = au_res;
			end
			smx_pkg::OP_SQRT: begin
				sp_we = 1'b1;
				sp_wa = d_m1[SAW-1:0];
				sp_wd = au_res;
			end
			smx_pkg::OP_PUSHR: begin
				ip_nx = ip_q + 16'd2;
				d_nx  = d_q + SDW'(1);
				sp_we = 1'b1;
				sp_wd = regv;
			end
			smx_pkg::OP_POPR, smx_pkg::OP_POPM: begin
				ip_nx = ip_q + 16'd2;
				d_nx  = d_m1;
			end
			smx_pkg::OP_JMP, smx_pkg::OP_CALL: begin
				ip_nx = arg_q[15:0];
			end
			smx_pkg::OP_JCOND: begin
				ip_nx = taken ? arg_q[15:0] : (ip_q + 16'd2);
				d_nx  = d_m2;
			end
			smx_pkg::OP_RET: begin
				ip_nx = rs_mem[rdp_m1[RAW-1:0]];
			end
			smx_pkg::OP_PUSHM: begin
				ip_nx = ip_q + 16'd2;
				d_nx  = d_q + SDW'(1);
				sp_we = 1'b1;
				sp_wd = dm_rd_q;
			end
			default: ip_nx = ip_q + 16'd1;
		endcase
		sp_we = sp_we && ok_commit;
	end

	assign sp_ra = ctl.rd_a ? d_m1[SAW-1:0] : d_m2[SAW-1:0];

	always_ff @(posedge clk) begin
		if (sp_we)
			sp_mem[sp_wa] <= sp_wd;
		if (ctl.rd_a || ctl.rd_b)
			sp_rd_q <= sp_mem[sp_ra];
		if (ctl.ld) begin
			op_q  <= cmd;
			arg_q <= argument;
			cnd_q <= condition;
		end
		if (ctl.rd_b)
			a_q <= sp_rd_q;
		if (ctl.rd_m)
			b_q <= sp_rd_q;
		if (ctl.rd_a) begin
			rg_rd_q <= rg_mem[arg_q[RGW-1:0]];
			rg_rv_q <= rg_vld_q[arg_q[RGW-1:0]];
		end
		if (ok_commit && op_q == smx_pkg::OP_POPR)
			rg_mem[arg_q[RGW-1:0]] <= a_q;
		if (ok_commit && op_q == smx_pkg::OP_CALL)
			rs_mem[rdp_q[RAW-1:0]] <= ip_q + 16'd2;
		if (ctl.commit) begin
			nip_q  <= (err == smx_pkg::ERR_OK) ? ip_nx : ip_q;
			pv_q   <= ok_commit && op_q == smx_pkg::OP_OUT;
			pval_q <= (ok_commit && op_q == smx_pkg::OP_OUT) ? a_q : 64'd0;
			err_q  <= err;
		end
	end

	// data RAM, zeroed by the clearing pass after reset
	assign dm_we   = ctl.clr || (ok_commit && op_q == smx_pkg::OP_POPM);
	assign dm_addr = ctl.clr ? clr_cnt_q : regv[MAW-1:0];
	assign dm_wd   = ctl.clr ? 64'd0 : a_q;

	always_ff @(posedge clk) begin
		if (dm_we)
			dm_mem[dm_addr] <= dm_wd;
		if (ctl.rd_m)
			dm_rd_q <= dm_mem[dm_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q      <= '0;
			d_q       <= '0;
			rdp_q     <= '0;
			fault_q   <= 1'b0;
			rg_vld_q  <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (ctl.clr)
				clr_cnt_q <= clr_cnt_q + MAW'(1);
			if (ctl.commit && err != smx_pkg::ERR_OK)
				fault_q <= 1'b1;
			if (ok_commit) begin
				ip_q <= ip_nx;
				d_q  <= d_nx;
				if (op_q == smx_pkg::OP_CALL)
					rdp_q <= rdp_q + RDW'(1);
				else if (op_q == smx_pkg::OP_RET)
					rdp_q <= rdp_m1;
				if (op_q == smx_pkg::OP_POPR)
					rg_vld_q[arg_q[RGW-1:0]] <= 1'b1;
			end
		end
	end

	smx_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start),
		.op     (au_op),
		.x      (b_q),
		.y      (a_q),
		.done   (au_done),
		.result (au_res)
	);

	assign sts.clr_last  = (clr_cnt_q == MAW'(MEM_WORDS - 1));
	assign sts.need_unit = (err == smx_pkg::ERR_OK) &&
		(op_q == smx_pkg::OP_MUL || op_q == smx_pkg::OP_DIV || op_q == smx_pkg::OP_SQRT);
	assign sts.unit_done = au_done;
	assign sts.fault     = fault_q;

	assign next_ip     = nip_q;
	assign print_valid = pv_q;
	assign print_value = pval_q;
	assign error_code  = err_q;

endmodule

/* rtl/smx_ctrl.sv */
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer: RAM clearing pass, operand reads, arithmetic wait, commit.
// ----------------------------------------------------------------------------
module smx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  smx_pkg::smx_sts_t sts,
	output smx_pkg::smx_ctl_t ctl
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_RD_A  = 8'b0000_0100,
		S_RD_B  = 8'b0000_1000,
		S_RD_M  = 8'b0001_0000,
		S_EXEC  = 8'b0010_0000,
		S_ITER  = 8'b0100_0000,
		S_WRITE = 8'b1000_0000
	} state_t;

	state_t state_q, state_nx;
	logic   o_vld_q;

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.clr = 1'b1;
				if (sts.clr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.ld   = 1'b1;
					state_nx = S_RD_A;
				end
			end
			S_RD_A: begin
				ctl.rd_a = 1'b1;
				state_nx = S_RD_B;
			end
			S_RD_B: begin
				ctl.rd_b = 1'b1;
				state_nx = S_RD_M;
			end
			S_RD_M: begin
				ctl.rd_m = 1'b1;
				state_nx = S_EXEC;
			end
			S_EXEC: begin
				if (sts.need_unit) begin
					ctl.start = 1'b1;
					state_nx  = S_ITER;
				end else begin
					state_nx = S_WRITE;
				end
			end
			S_ITER: begin
				if (sts.unit_done) state_nx = S_WRITE;
			end
			S_WRITE: begin
				// result register must be free or draining this cycle
				if (!o_vld_q || rsp_ready) begin
					ctl.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			o_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.commit)
				o_vld_q <= 1'b1;
			else if (rsp_ready)
				o_vld_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = o_vld_q;

endmodule

/* rtl/stack_machine_execute_top.sv */
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// Executes one fetched stack machine instruction per request word.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one instruction word (cmd, argument, condition); rsp returns
//   one result word per instruction (next_ip, print_valid, print_value,
//   error_code). Both are valid/ready; a word moves when both are high.
// Sequencing: one instruction at a time. Ordinary opcodes pass through idle,
//   two stack reads, register/RAM read, check and commit before the next
//   acceptance; the stack RAM read port sets this. mul, div and sqrt also
//   wait in the shared bit-serial arithmetic unit.
// Reset: arst_n clears all control state, the stacks to empty, registers to
//   zero and the fault flag. Then a clearing pass zeroes the data RAM, one
//   word per cycle; req.ready stays low meanwhile.
// Stall: the result sits in an output register; the next instruction is
//   accepted and worked on, and it waits at commit only while the previous
//   result word has not yet been taken.
// Errors leave state untouched, report next_ip = current ip and set a
//   sticky internal fault flag.
// ----------------------------------------------------------------------------
module stack_machine_execute_top #(
	parameter int unsigned STACK_DEPTH  = smx_pkg::STACK_DEPTH_DEF,
	parameter int unsigned RETURN_DEPTH = smx_pkg::RETURN_DEPTH_DEF,
	parameter int unsigned REG_COUNT    = smx_pkg::REG_COUNT_DEF,
	parameter int unsigned MEM_WORDS    = smx_pkg::MEM_WORDS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	smx_req_if.sink  req,
	smx_rsp_if.source rsp
);

	smx_pkg::smx_ctl_t ctl;
	smx_pkg::smx_sts_t sts;

	smx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	smx_dpath #(
		.STACK_DEPTH  (STACK_DEPTH),
		.RETURN_DEPTH (RETURN_DEPTH),
		.REG_COUNT    (REG_COUNT),
		.MEM_WORDS    (MEM_WORDS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (req.cmd),
		.argument    (req.argument),
		.condition   (req.condition),
		.next_ip     (rsp.next_ip),
		.print_valid (rsp.print_valid),
		.print_value (rsp.print_value),
		.error_code  (rsp.error_code)
	);

	// one instruction in flight: no acceptance right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while an instruction is in flight");

	// fault flag is sticky
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(sts.fault))
		else $error("fault flag cleared without reset");

	// a faulting result word never prints
	a_err_no_print: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error_code != smx_pkg::ERR_OK |-> !rsp.print_valid)
		else $error("print flagged on an error result");

	// commit never overwrites an untaken result word
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !rsp.valid || rsp.ready)
		else $error("result word overwritten");

endmodule
